// File: hw/rtl/dynamic_resolution_governor_defines.svh
// ----------------------------------------------------------------------------
// Dynamic resolution governor assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_RESOLUTION_GOVERNOR_DEFINES_SVH
`define DYNAMIC_RESOLUTION_GOVERNOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define DRG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition implies another one on the next clock edge.
`define DRG_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define DRG_ASSERT(lbl, clk, rstn, prop, msg)
`define DRG_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

// File: hw/rtl/drg_pkg.sv
// ----------------------------------------------------------------------------
// Dynamic resolution governor package
// Shared types, register indexes and fixed constants of the governor.
// ----------------------------------------------------------------------------
package drg_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_PREFER_GPU = 3'd1,
    REG_TARGET     = 3'd2,
    REG_HYSTERESIS = 3'd3,
    REG_ALPHA      = 3'd4,
    REG_MIN_PCT    = 3'd5,
    REG_MAX_PCT    = 3'd6,
    REG_STEP_PCT   = 3'd7
  } reg_index_e;

  localparam int unsigned CfgDataW = 20;

  // Fixed behavior constants
  localparam logic [6:0]  WAIT_AFTER_DROP      = 7'd30;
  localparam logic [6:0]  WAIT_AFTER_RAISE     = 7'd60;
  localparam logic [6:0]  COOLDOWN_MAX         = 7'd60;
  localparam logic [3:0]  MAX_DROPS_PER_SECOND = 4'd4;
  localparam logic [21:0] US_PER_SECOND        = 22'd1000000;

  // Clamp limits of the registers
  localparam logic [19:0] TARGET_MIN = 20'd1000;
  localparam logic [19:0] TARGET_MAX = 20'd1000000;
  localparam logic [8:0]  ALPHA_MIN  = 9'd3;
  localparam logic [8:0]  ALPHA_MAX  = 9'd256;
  localparam logic [6:0]  PCT_MIN    = 7'd1;
  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [3:0]  STEP_MIN   = 4'd1;
  localparam logic [3:0]  STEP_MAX   = 4'd10;

  // Clamped configuration seen by the core
  typedef struct packed {
    logic        enable;
    logic        prefer_gpu;
    logic [19:0] target_us;
    logic [19:0] hysteresis_us;
    logic [8:0]  alpha;
    logic [6:0]  lo_pct;
    logic [6:0]  hi_pct;
    logic [3:0]  step_pct;
  } cfg_t;

  // One timing sample
  typedef struct packed {
    logic [19:0] gpu_time_us;
    logic        gpu_time_valid;
    logic [19:0] cpu_time_us;
    logic [19:0] frame_time_us;
  } sample_t;

  // One result
  typedef struct packed {
    logic [6:0]  resolution_percent;
    logic [19:0] filtered_time_us;
    logic        resolution_changed;
    logic        active;
  } result_t;

endpackage

// File: hw/rtl/drg_filter.sv
// ----------------------------------------------------------------------------
// Dynamic resolution governor smoothing filter
// Exponential filter in 20.8 fixed point with weight in 1/256 units.
// ----------------------------------------------------------------------------
module drg_filter (
  input  logic [27:0] smoothed_i,
  input  logic [19:0] raw_i,
  input  logic [8:0]  alpha_i,
  output logic [27:0] filtered_o
);

  logic [8:0]  keep_w;
  logic [36:0] old_prod_w;
  logic [28:0] new_prod_w;
  logic [37:0] sum_w;

  // Weight the old value and the new sample, round half up
  assign keep_w     = 9'd256 - alpha_i;
  assign old_prod_w = 37'(smoothed_i) * 37'(keep_w);
  assign new_prod_w = 29'(raw_i) * 29'(alpha_i);
  assign sum_w      = {1'b0, old_prod_w} + {1'b0, new_prod_w, 8'd0} + 38'd128;
  assign filtered_o = sum_w[35:8];

endmodule

// File: hw/rtl/drg_core.sv
// ----------------------------------------------------------------------------
// Dynamic resolution governor core
// Governor state and the per-frame decision, one item per step.
// ----------------------------------------------------------------------------
`include "dynamic_resolution_governor_defines.svh"

module drg_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  drg_pkg::sample_t sample_i,
  input  drg_pkg::cfg_t    cfg_i,
  output drg_pkg::result_t result_o
);

  logic        running_q, running_d;
  logic [6:0]  resolution_q, resolution_d;
  logic [27:0] smoothed_q, smoothed_d;
  logic [6:0]  wait_q, wait_d;
  logic [3:0]  drops_q, drops_d;
  logic [20:0] sec_acc_q, sec_acc_d;

  logic [19:0] raw_w;
  logic [27:0] filtered_w;
  logic [21:0] sec_sum_w;
  logic [6:0]  cur_w;
  logic [6:0]  nxt_w;
  logic [7:0]  lo_step_w;
  logic [28:0] upper_w;
  logic [19:0] lower_us_w;

  // Pick the raw time, floored at 1 us
  always_comb begin
    if (cfg_i.prefer_gpu && sample_i.gpu_time_valid && (sample_i.gpu_time_us != '0)) begin
      raw_w = sample_i.gpu_time_us;
    end else if (sample_i.frame_time_us != '0) begin
      raw_w = sample_i.frame_time_us;
    end else if (sample_i.cpu_time_us != '0) begin
      raw_w = sample_i.cpu_time_us;
    end else begin
      raw_w = 20'd1;
    end
  end

  drg_filter u_filter (
    .smoothed_i (smoothed_q),
    .raw_i      (raw_w),
    .alpha_i    (cfg_i.alpha),
    .filtered_o (filtered_w)
  );

  assign sec_sum_w  = {1'b0, sec_acc_q} + {2'b00, sample_i.frame_time_us};
  assign lo_step_w  = {1'b0, cfg_i.lo_pct} + {4'd0, cfg_i.step_pct};
  assign upper_w    = {({1'b0, cfg_i.target_us} + {1'b0, cfg_i.hysteresis_us}), 8'd0};
  assign lower_us_w = cfg_i.target_us - cfg_i.hysteresis_us;

  // Clamp the held resolution into the current band
  always_comb begin
    if (resolution_q < cfg_i.lo_pct) begin
      cur_w = cfg_i.lo_pct;
    end else if (resolution_q > cfg_i.hi_pct) begin
      cur_w = cfg_i.hi_pct;
    end else begin
      cur_w = resolution_q;
    end
  end

  // Decide the next state and the result
  always_comb begin
    running_d    = running_q;
    resolution_d = resolution_q;
    smoothed_d   = smoothed_q;
    wait_d       = wait_q;
    drops_d      = drops_q;
    sec_acc_d    = sec_acc_q;
    nxt_w        = cur_w;
    result_o     = '0;

    if (!cfg_i.enable) begin
      // Disabled: drop all kept state
      running_d    = 1'b0;
      resolution_d = '0;
      smoothed_d   = '0;
      wait_d       = '0;
      drops_d      = '0;
      sec_acc_d    = '0;
    end else if (!running_q) begin
      // First frame: initialize only
      running_d    = 1'b1;
      resolution_d = cfg_i.hi_pct;
      smoothed_d   = {raw_w, 8'd0};
      wait_d       = '0;
      drops_d      = '0;
      sec_acc_d    = '0;
      result_o.resolution_percent = cfg_i.hi_pct;
      result_o.filtered_time_us   = raw_w;
      result_o.active             = 1'b1;
    end else begin
      smoothed_d = filtered_w;

      // Advance the one-second window on known frame times
      if (sample_i.frame_time_us != '0) begin
        if (sec_sum_w >= drg_pkg::US_PER_SECOND) begin
          drops_d   = '0;
          sec_acc_d = 21'(sec_sum_w - drg_pkg::US_PER_SECOND);
        end else begin
          sec_acc_d = sec_sum_w[20:0];
        end
      end

      if ({1'b0, filtered_w} > upper_w) begin
        // Too slow: step down within the drop budget
        if (drops_d < drg_pkg::MAX_DROPS_PER_SECOND) begin
          if ({1'b0, cur_w} > lo_step_w) begin
            nxt_w = cur_w - {3'd0, cfg_i.step_pct};
          end else begin
            nxt_w = cfg_i.lo_pct;
          end
          drops_d = drops_d + 4'd1;
        end
        wait_d = drg_pkg::WAIT_AFTER_DROP;
      end else if ((cfg_i.target_us > cfg_i.hysteresis_us) &&
                   (filtered_w < {lower_us_w, 8'd0})) begin
        // Fast enough: jump up once the cooldown has expired
        if (wait_q != '0) begin
          wait_d = wait_q - 7'd1;
        end else begin
          nxt_w  = cfg_i.hi_pct;
          wait_d = drg_pkg::WAIT_AFTER_RAISE;
        end
      end else if (wait_q != '0) begin
        wait_d = wait_q - 7'd1;
      end

      resolution_d = nxt_w;
      result_o.resolution_percent = nxt_w;
      result_o.filtered_time_us   = filtered_w[27:8];
      result_o.resolution_changed = (nxt_w != cur_w);
      result_o.active             = 1'b1;
    end
  end

  // Update state on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      resolution_q <= '0;
      smoothed_q   <= '0;
      wait_q       <= '0;
      drops_q      <= '0;
      sec_acc_q    <= '0;
    end else if (step_i) begin
      running_q    <= running_d;
      resolution_q <= resolution_d;
      smoothed_q   <= smoothed_d;
      wait_q       <= wait_d;
      drops_q      <= drops_d;
      sec_acc_q    <= sec_acc_d;
    end
  end

  `DRG_ASSERT(a_res_range, clk_i, rst_ni, !running_q || ((resolution_q >= drg_pkg::PCT_MIN) && (resolution_q <= drg_pkg::PCT_MAX)), "resolution out of range while running")
  `DRG_ASSERT(a_idle_clear, clk_i, rst_ni, running_q || ((resolution_q == '0) && (smoothed_q == '0) && (wait_q == '0)), "state kept while not running")
  `DRG_ASSERT(a_wait_bound, clk_i, rst_ni, wait_q <= drg_pkg::COOLDOWN_MAX, "cooldown above its load value")
  `DRG_ASSERT(a_drop_budget, clk_i, rst_ni, drops_q <= drg_pkg::MAX_DROPS_PER_SECOND, "drop count above budget")
  `DRG_ASSERT_NEXT(a_disable_clears, clk_i, rst_ni, step_i && !cfg_i.enable, !running_q, "disable did not clear state")

endmodule

// File: hw/rtl/dynamic_resolution_governor.sv
// ----------------------------------------------------------------------------
// Dynamic resolution governor
// Turns per-frame timing samples into a dynamic resolution percent.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one frame's timing sample per item; m_axis returns one
//   result item per sample, in order. Registers are written through the
//   cfg_we_i / cfg_index_i / cfg_wdata_i port while no item is in flight.
// Path: the item lands in the input register at the accept edge; its result
//   is written to the result register when the core steps it, which waits
//   for a free result slot. Throughput: one item per cycle while m_axis_tready
//   is high; the filter multiply and the threshold compares sit between the
//   input and result registers, and all governor state updates on that step.
// Stall: when m_axis_tready is low the result register holds; one more item
//   is taken into the input register, after which s_axis_tready drops.
// Reset: registers return to their defaults (governor disabled), the
//   governor state is cleared and both pipeline stages are emptied. The first
//   item after enabling only initializes the state and reports the maximum.
// ----------------------------------------------------------------------------
module dynamic_resolution_governor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // gpu_time_us, cpu_time_us, frame_time_us, zero pad
  input  logic        s_axis_tuser,   // gpu_time_valid
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // resolution_percent, filtered_time_us, zero pad
  output logic [1:0]  m_axis_tuser    // resolution_changed, active
);

  logic        enable_q;
  logic        prefer_gpu_q;
  logic [19:0] target_q;
  logic [19:0] hyst_q;
  logic [8:0]  alpha_q;
  logic [6:0]  min_pct_q;
  logic [6:0]  max_pct_q;
  logic [3:0]  step_pct_q;

  drg_pkg::cfg_t    cfg_w;
  drg_pkg::sample_t in_q;
  logic             in_valid_q;
  drg_pkg::result_t res_w;
  drg_pkg::result_t out_q;
  logic             out_valid_q;
  logic             out_free_w;
  logic             step_w;
  drg_pkg::reg_index_e cfg_idx_w;

  // Write configuration registers
  assign cfg_idx_w = drg_pkg::reg_index_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      prefer_gpu_q <= 1'b1;
      target_q     <= 20'd16667;
      hyst_q       <= 20'd1000;
      alpha_q      <= 9'd26;
      min_pct_q    <= 7'd50;
      max_pct_q    <= 7'd100;
      step_pct_q   <= 4'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_w)
        drg_pkg::REG_ENABLE:     enable_q     <= cfg_wdata_i[0];
        drg_pkg::REG_PREFER_GPU: prefer_gpu_q <= cfg_wdata_i[0];
        drg_pkg::REG_TARGET:     target_q     <= cfg_wdata_i;
        drg_pkg::REG_HYSTERESIS: hyst_q       <= cfg_wdata_i;
        drg_pkg::REG_ALPHA:      alpha_q      <= cfg_wdata_i[8:0];
        drg_pkg::REG_MIN_PCT:    min_pct_q    <= cfg_wdata_i[6:0];
        drg_pkg::REG_MAX_PCT:    max_pct_q    <= cfg_wdata_i[6:0];
        drg_pkg::REG_STEP_PCT:   step_pct_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the target, alpha, percent and step registers into their legal ranges
  always_comb begin
    cfg_w.enable        = enable_q;
    cfg_w.prefer_gpu    = prefer_gpu_q;
    cfg_w.hysteresis_us = hyst_q;

    if (target_q < drg_pkg::TARGET_MIN) begin
      cfg_w.target_us = drg_pkg::TARGET_MIN;
    end else if (target_q > drg_pkg::TARGET_MAX) begin
      cfg_w.target_us = drg_pkg::TARGET_MAX;
    end else begin
      cfg_w.target_us = target_q;
    end

    if (alpha_q < drg_pkg::ALPHA_MIN) begin
      cfg_w.alpha = drg_pkg::ALPHA_MIN;
    end else if (alpha_q > drg_pkg::ALPHA_MAX) begin
      cfg_w.alpha = drg_pkg::ALPHA_MAX;
    end else begin
      cfg_w.alpha = alpha_q;
    end

    if (min_pct_q < drg_pkg::PCT_MIN) begin
      cfg_w.lo_pct = drg_pkg::PCT_MIN;
    end else if (min_pct_q > drg_pkg::PCT_MAX) begin
      cfg_w.lo_pct = drg_pkg::PCT_MAX;
    end else begin
      cfg_w.lo_pct = min_pct_q;
    end

    if (max_pct_q < cfg_w.lo_pct) begin
      cfg_w.hi_pct = cfg_w.lo_pct;
    end else if (max_pct_q > drg_pkg::PCT_MAX) begin
      cfg_w.hi_pct = drg_pkg::PCT_MAX;
    end else begin
      cfg_w.hi_pct = max_pct_q;
    end

    if (step_pct_q < drg_pkg::STEP_MIN) begin
      cfg_w.step_pct = drg_pkg::STEP_MIN;
    end else if (step_pct_q > drg_pkg::STEP_MAX) begin
      cfg_w.step_pct = drg_pkg::STEP_MAX;
    end else begin
      cfg_w.step_pct = step_pct_q;
    end
  end

  // Handshake: process when an item waits and the result slot frees up
  assign out_free_w    = !out_valid_q || m_axis_tready;
  assign step_w        = in_valid_q && out_free_w;
  assign s_axis_tready = !in_valid_q || out_free_w;

  // Hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.gpu_time_us    <= s_axis_tdata[19:0];
      in_q.gpu_time_valid <= s_axis_tuser;
      in_q.cpu_time_us    <= s_axis_tdata[39:20];
      in_q.frame_time_us  <= s_axis_tdata[59:40];
    end
  end

  drg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step_w),
    .sample_i (in_q),
    .cfg_i    (cfg_w),
    .result_o (res_w)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free_w) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_w) begin
      out_q <= res_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.filtered_time_us, out_q.resolution_percent};
  assign m_axis_tuser  = {out_q.active, out_q.resolution_changed};

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Dynamic resolution governor testbench
// Streams frame timing samples through the governor and checks every result
// against a cycle-free model of the governor kept inside this bench. Directed
// cases cover source selection, the first frame, drop limiting, the second
// rollover, upscale after cooldown and register clamping. Random load phases
// then run under several register settings, with bursts of idling on both
// sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PIPE_LAT    = 2;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX20       = 20'hFFFFF;

  logic                         clk_i;
  logic                         rst_n;
  logic                         cfg_we;
  drg_pkg::reg_index_e          cfg_index;
  logic [drg_pkg::CfgDataW-1:0] cfg_wdata;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [63:0]                  s_axis_tdata;
  logic                         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [31:0]                  m_axis_tdata;
  logic [1:0]                   m_axis_tuser;

  // Register copies as written, at the register widths
  logic        cf_enable     = 1'b0;
  logic        cf_prefer_gpu = 1'b1;
  logic [19:0] cf_target     = 20'd16667;
  logic [19:0] cf_hyst       = 20'd1000;
  logic [8:0]  cf_alpha      = 9'd26;
  logic [6:0]  cf_min_pct    = 7'd50;
  logic [6:0]  cf_max_pct    = 7'd100;
  logic [3:0]  cf_step_pct   = 4'd5;

  // Governor state as predicted
  logic        gv_running = 1'b0;
  logic [6:0]  gv_res     = '0;
  logic [27:0] gv_smooth  = '0;
  logic [6:0]  gv_wait    = '0;
  logic [3:0]  gv_drops   = '0;
  logic [20:0] gv_secacc  = '0;

  drg_pkg::result_t pend_res_q[$];

  // Bench control and bookkeeping
  logic        tx_idle  = 1'b0;
  logic        stall_on = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned n_cycles   = 0;
  int unsigned n_errors   = 0;
  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_changes  = 0;
  int unsigned n_settings = 0;

  dynamic_resolution_governor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the predicted governor by one frame and return its result
  function automatic drg_pkg::result_t govern_frame(drg_pkg::sample_t s);
    drg_pkg::result_t r;
    int unsigned      raw, target, alpha, lo, hi, step, cur, nxt, acc_s;
    longint unsigned  sm, lraw, mix, upper, lower;
    r = '0;
    if (!cf_enable) begin
      gv_running = 1'b0;
      gv_res     = '0;
      gv_smooth  = '0;
      gv_wait    = '0;
      gv_drops   = '0;
      gv_secacc  = '0;
      return r;
    end

    if (cf_prefer_gpu && s.gpu_time_valid && s.gpu_time_us != 0) raw = 32'(s.gpu_time_us);
    else if (s.frame_time_us != 0) raw = 32'(s.frame_time_us);
    else raw = 32'(s.cpu_time_us);
    if (raw == 0) raw = 1;

    target = clamp_u(32'(cf_target), 32'(drg_pkg::TARGET_MIN), 32'(drg_pkg::TARGET_MAX));
    alpha  = clamp_u(32'(cf_alpha), 32'(drg_pkg::ALPHA_MIN), 32'(drg_pkg::ALPHA_MAX));
    lo     = clamp_u(32'(cf_min_pct), 32'(drg_pkg::PCT_MIN), 32'(drg_pkg::PCT_MAX));
    hi     = clamp_u(32'(cf_max_pct), lo, 32'(drg_pkg::PCT_MAX));
    step   = clamp_u(32'(cf_step_pct), 32'(drg_pkg::STEP_MIN), 32'(drg_pkg::STEP_MAX));

    // First frame after enabling: seed the filter, report the maximum
    if (!gv_running) begin
      gv_running  = 1'b1;
      gv_res      = hi[6:0];
      gv_smooth   = {raw[19:0], 8'h00};
      gv_wait     = '0;
      gv_drops    = '0;
      gv_secacc   = '0;
      r.resolution_percent = hi[6:0];
      r.filtered_time_us   = raw[19:0];
      r.active             = 1'b1;
      return r;
    end

    // Exponential filter in 20.8 fixed point, rounding half up
    sm        = 64'(gv_smooth);
    lraw      = 64'(raw);
    mix       = sm * 64'(256 - alpha) + (lraw << 8) * 64'(alpha) + 64'd128;
    gv_smooth = mix[35:8];
    sm        = 64'(gv_smooth);

    // Accumulate frame time; a full second clears the drop count
    if (s.frame_time_us != 0) begin
      acc_s = 32'(gv_secacc) + 32'(s.frame_time_us);
      if (acc_s >= 32'(drg_pkg::US_PER_SECOND)) begin
        gv_drops = '0;
        acc_s    = acc_s - 32'(drg_pkg::US_PER_SECOND);
      end
      gv_secacc = acc_s[20:0];
    end

    cur   = clamp_u(32'(gv_res), lo, hi);
    nxt   = cur;
    upper = 64'(target) + 64'(cf_hyst);
    upper = upper << 8;
    lower = 0;
    if (target > 32'(cf_hyst)) begin
      lower = 64'(target - 32'(cf_hyst));
      lower = lower << 8;
    end

    if (sm > upper) begin
      if (gv_drops < drg_pkg::MAX_DROPS_PER_SECOND) begin
        nxt      = (cur > lo + step) ? cur - step : lo;
        gv_drops = gv_drops + 4'd1;
      end
      gv_wait = drg_pkg::WAIT_AFTER_DROP;
    end else if (sm < lower) begin
      if (gv_wait > 0) begin
        gv_wait = gv_wait - 7'd1;
      end else begin
        nxt     = hi;
        gv_wait = drg_pkg::WAIT_AFTER_RAISE;
      end
    end else if (gv_wait > 0) begin
      gv_wait = gv_wait - 7'd1;
    end

    gv_res = nxt[6:0];
    r.resolution_percent = nxt[6:0];
    r.filtered_time_us   = gv_smooth[27:8];
    r.resolution_changed = (nxt != cur);
    r.active             = 1'b1;
    return r;
  endfunction

  function automatic drg_pkg::sample_t frame_of(int unsigned gpu, bit gpu_ok,
                                                int unsigned cpu, int unsigned frame);
    drg_pkg::sample_t s;
    s.gpu_time_us    = gpu[19:0];
    s.gpu_time_valid = gpu_ok;
    s.cpu_time_us    = cpu[19:0];
    s.frame_time_us  = frame[19:0];
    return s;
  endfunction

  // Random frame around a load level, with some noise and missing fields
  function automatic drg_pkg::sample_t make_sample(int unsigned level);
    drg_pkg::sample_t s;
    int unsigned      pick, t, f, c;
    pick = $urandom_range(0, 99);
    t = level - level / 8 + $urandom_range(0, level / 4);
    if (t > MAX20) t = MAX20;
    if (t == 0) t = 1;
    f = t + $urandom_range(0, 200);
    if (f > MAX20) f = MAX20;
    c = t / 2 + $urandom_range(0, t / 2);
    s = frame_of(t, ($urandom_range(0, 9) != 0), c, f);
    if (pick < 10) begin
      s.gpu_time_us    = 20'($urandom);
      s.gpu_time_valid = 1'($urandom);
      s.cpu_time_us    = 20'($urandom);
      s.frame_time_us  = 20'($urandom);
    end else if (pick < 20) begin
      if ($urandom_range(0, 1) == 0) s.gpu_time_us = '0;
      if ($urandom_range(0, 1) == 0) s.frame_time_us = '0;
      if ($urandom_range(0, 3) == 0) s.cpu_time_us = '0;
    end
    return s;
  endfunction

  // Write one register and mirror it
  task automatic write_reg(drg_pkg::reg_index_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[drg_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    case (idx)
      drg_pkg::REG_ENABLE:     cf_enable     = val[0];
      drg_pkg::REG_PREFER_GPU: cf_prefer_gpu = val[0];
      drg_pkg::REG_TARGET:     cf_target     = val[19:0];
      drg_pkg::REG_HYSTERESIS: cf_hyst       = val[19:0];
      drg_pkg::REG_ALPHA:      cf_alpha      = val[8:0];
      drg_pkg::REG_MIN_PCT:    cf_min_pct    = val[6:0];
      drg_pkg::REG_MAX_PCT:    cf_max_pct    = val[6:0];
      drg_pkg::REG_STEP_PCT:   cf_step_pct   = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Offer one frame, with an optional idle burst first, and wait for accept
  task automatic offer_frame(drg_pkg::sample_t s);
    @(negedge clk_i);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'h0, s.frame_time_us, s.cpu_time_us, s.gpu_time_us};
    s_axis_tuser  = s.gpu_time_valid;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pend_res_q.push_back(govern_frame(s));
    n_sent++;
  endtask

  // Stop offering and let the pipeline empty out
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pend_res_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic load_settings(int unsigned prefer, int unsigned target, int unsigned hyst,
                               int unsigned alpha, int unsigned min_p, int unsigned max_p,
                               int unsigned step);
    drain_results();
    write_reg(drg_pkg::REG_PREFER_GPU, prefer);
    write_reg(drg_pkg::REG_TARGET, target);
    write_reg(drg_pkg::REG_HYSTERESIS, hyst);
    write_reg(drg_pkg::REG_ALPHA, alpha);
    write_reg(drg_pkg::REG_MIN_PCT, min_p);
    write_reg(drg_pkg::REG_MAX_PCT, max_p);
    write_reg(drg_pkg::REG_STEP_PCT, step);
    write_reg(drg_pkg::REG_ENABLE, 1);
    n_settings++;
  endtask

  // Random load: hold a level for a run of frames, then pick another
  task automatic run_load(int unsigned n_items, bit allow_idle);
    int unsigned left, level, target;
    left   = 0;
    level  = 1;
    target = clamp_u(32'(cf_target), 32'(drg_pkg::TARGET_MIN), 32'(drg_pkg::TARGET_MAX));
    repeat (n_items) begin
      if (left == 0) begin
        left = $urandom_range(10, 70);
        case ($urandom_range(0, 4))
          0: level = target / 2;
          1: level = target * 3 / 4;
          2: level = target;
          3: level = target * 5 / 4;
          default: level = target * 2;
        endcase
        tx_idle  = allow_idle && ($urandom_range(0, 3) != 0);
        stall_on = allow_idle && ($urandom_range(0, 3) != 0);
      end
      left--;
      offer_frame(make_sample(level));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_disabled_frames();
    write_reg(drg_pkg::REG_ENABLE, 0);
    write_reg(drg_pkg::REG_PREFER_GPU, 1);
    write_reg(drg_pkg::REG_TARGET, 16667);
    write_reg(drg_pkg::REG_HYSTERESIS, 1000);
    write_reg(drg_pkg::REG_ALPHA, 32'(drg_pkg::ALPHA_MAX));
    write_reg(drg_pkg::REG_MIN_PCT, 50);
    write_reg(drg_pkg::REG_MAX_PCT, 80);
    write_reg(drg_pkg::REG_STEP_PCT, 5);
    n_settings++;
    offer_frame(frame_of(MAX20, 1, MAX20, MAX20));
    offer_frame(frame_of(0, 0, 0, 0));
  endtask

  task automatic test_first_frame_and_upscale();
    drain_results();
    write_reg(drg_pkg::REG_ENABLE, 1);
    // All times zero: floor at one microsecond
    offer_frame(frame_of(0, 0, 0, 0));
    drain_results();
    write_reg(drg_pkg::REG_MAX_PCT, 100);
    // Light frame with the cooldown at zero: jump to the new maximum
    offer_frame(frame_of(5000, 1, 5000, 5000));
  endtask

  task automatic test_drops_and_sources();
    // Heavy frames: four drops, then the limit holds the percent
    repeat (6) offer_frame(frame_of(MAX20, 1, 1000, 1000));
    // GPU invalid, long host frame: second rolls over and drops resume
    offer_frame(frame_of(MAX20, 0, 2000, MAX20));
    // No GPU, no host time: fall back to CPU time
    offer_frame(frame_of(MAX20, 0, MAX20, 0));
    drain_results();
    write_reg(drg_pkg::REG_PREFER_GPU, 0);
    offer_frame(frame_of(1, 1, 3, 20000));
    offer_frame(frame_of(1, 1, 3, 16667));
  endtask

  task automatic test_clamp_and_reenable();
    drain_results();
    write_reg(drg_pkg::REG_MAX_PCT, 60);
    // Previous percent is clamped into the new range
    offer_frame(frame_of(0, 0, 0, 16667));
    drain_results();
    write_reg(drg_pkg::REG_ENABLE, 0);
    offer_frame(frame_of(12345, 1, 54321, 16667));
    drain_results();
    write_reg(drg_pkg::REG_ENABLE, 1);
    offer_frame(frame_of(MAX20, 1, 0, 0));
  endtask

  task automatic test_default_load();
    load_settings(1, 16667, 1000, 26, 50, 100, 5);
    run_load(230, 1);
  endtask

  task automatic test_fast_filter();
    load_settings(0, 32'(drg_pkg::TARGET_MIN), 0, 32'(drg_pkg::ALPHA_MAX),
                  32'(drg_pkg::PCT_MIN), 32'(drg_pkg::PCT_MAX), 32'(drg_pkg::STEP_MAX));
    run_load(180, 1);
  endtask

  task automatic test_long_frames();
    load_settings(1, 32'(drg_pkg::TARGET_MAX), 0, 32'(drg_pkg::ALPHA_MIN), 100, 100,
                  32'(drg_pkg::STEP_MIN));
    run_load(100, 1);
    // Hysteresis above the target: the upscale side never fires
    load_settings(1, 32'(drg_pkg::TARGET_MAX), MAX20, 32'(drg_pkg::ALPHA_MIN), 10, 90, 3);
    run_load(60, 1);
  endtask

  task automatic test_out_of_range_regs();
    load_settings(1, 0, 200, 511, 0, 127, 15);
    run_load(100, 1);
    load_settings(0, MAX20, 5000, 0, 127, 0, 0);
    run_load(60, 1);
    // Drop the enable mid-stream and come back up
    drain_results();
    write_reg(drg_pkg::REG_ENABLE, 0);
    run_load(10, 1);
    drain_results();
    write_reg(drg_pkg::REG_ENABLE, 1);
    run_load(30, 1);
  endtask

  task automatic test_backpressure();
    load_settings(1, 8333, 500, 64, 30, 90, 7);
    tx_idle  = 1'b0;
    stall_on = 1'b0;
    hold_req = 1'b1;
    run_load(60, 0);
  endtask

  task automatic test_closing_stream();
    load_settings(1, 11111, 700, 128, 40, 95, 6);
    tx_idle  = 1'b0;
    stall_on = 1'b0;
    run_load(150, 0);
  endtask

  // ---------------------------------------------------------------- processes

  // Result receiver: random stall bursts, or one long hold-off on request
  initial begin : rx_ready
    int unsigned n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        n = $urandom_range(1, 13);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : chk_res
    drg_pkg::result_t got, want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got.resolution_percent = m_axis_tdata[6:0];
      got.filtered_time_us   = m_axis_tdata[26:7];
      got.resolution_changed = m_axis_tuser[0];
      got.active             = m_axis_tuser[1];
      if (pend_res_q.size() == 0) begin
        if (n_errors < 10) $display("ERROR: result with no frame pending: %p", got);
        n_errors++;
      end else begin
        want = pend_res_q.pop_front();
        n_checked++;
        if (got.resolution_changed) n_changes++;
        if (got !== want) begin
          if (n_errors < 10) begin
            $display("ERROR: result %0d mismatch", n_checked);
            $display("  expected pct=%0d filt=%0d chg=%0b act=%0b",
                     want.resolution_percent, want.filtered_time_us,
                     want.resolution_changed, want.active);
            $display("  actual   pct=%0d filt=%0d chg=%0b act=%0b",
                     got.resolution_percent, got.filtered_time_us,
                     got.resolution_changed, got.active);
          end
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", n_cycles,
               pend_res_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = drg_pkg::REG_ENABLE;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_n = 1'b1;

    test_disabled_frames();
    test_first_frame_and_upscale();
    test_drops_and_sources();
    test_clamp_and_reenable();
    test_default_load();
    test_fast_filter();
    test_long_frames();
    test_out_of_range_regs();
    test_backpressure();
    test_closing_stream();
    drain_results();
    repeat (PIPE_LAT + 8) @(posedge clk_i);

    $display("Ran %0d frames through %0d register settings, %0d results checked,",
             n_sent, n_settings, n_checked);
    $display("%0d resolution changes seen, %0d mismatches", n_changes, n_errors);
    if (n_errors == 0 && pend_res_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: dynamic_resolution_governor.f
+incdir+hw/rtl
hw/rtl/drg_pkg.sv
hw/rtl/drg_filter.sv
hw/rtl/drg_core.sv
hw/rtl/dynamic_resolution_governor.sv
tb/testbench.sv
